// ===== rtl/hsvrgb_pkg.sv =====
// Shared types and constants for the HSV to RGB converter with brightness scaling.
// Used by every module of the block; depends on nothing else.
package hsvrgb_pkg;

	localparam logic [8:0] HUE_MAX    = 9'd359;
	localparam int         SECTOR_DEG = 60;
	localparam logic [7:0] FULL_SCALE = 8'd255;

	// floor(n / 15) == (n * RECIP15) >> 16 for every n below 4681.
	localparam logic [12:0] RECIP15 = 13'd4370;

	localparam logic [7:0] SAT_RESET  = 8'd255;
	localparam logic [7:0] VAL_RESET  = 8'd80;
	localparam logic [7:0] BRI_RESET  = 8'd250;

	typedef enum logic [1:0] {
		CFG_SATURATION     = 2'd0,
		CFG_VALUE_LEVEL    = 2'd1,
		CFG_MAX_BRIGHTNESS = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t    sector;
		logic [5:0] frac;
		logic [7:0] top;
		logic [7:0] floor_lvl;
	} sect_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

endpackage

// ===== rtl/hsvrgb_sector.sv =====
// First pipeline stage: hue clamp, sector and remainder, and the floor level.
// Depends on hsvrgb_pkg.
module hsvrgb_sector import hsvrgb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [8:0] hue,
	input  logic [7:0] saturation,
	input  logic [7:0] value_level,
	output logic       out_valid,
	input  logic       out_ready,
	output sect_t      out_data
);

	logic        v_s1;
	sect_t       data_s1;
	logic [8:0]  hue_c;
	logic [8:0]  base;
	sector_t     sector;
	logic [15:0] floor_prod;
	sect_t       nxt;

	assign in_ready = !v_s1 || out_ready;

	always_comb begin
		hue_c = (hue > HUE_MAX) ? HUE_MAX : hue;
		priority if (hue_c >= 9'(5 * SECTOR_DEG)) begin
			sector = SEC_MAG_RED;
			base   = 9'(5 * SECTOR_DEG);
		end else if (hue_c >= 9'(4 * SECTOR_DEG)) begin
			sector = SEC_BLU_MAG;
			base   = 9'(4 * SECTOR_DEG);
		end else if (hue_c >= 9'(3 * SECTOR_DEG)) begin
			sector = SEC_CYN_BLU;
			base   = 9'(3 * SECTOR_DEG);
		end else if (hue_c >= 9'(2 * SECTOR_DEG)) begin
			sector = SEC_GRN_CYN;
			base   = 9'(2 * SECTOR_DEG);
		end else if (hue_c >= 9'(SECTOR_DEG)) begin
			sector = SEC_YEL_GRN;
			base   = 9'(SECTOR_DEG);
		end else begin
			sector = SEC_RED_YEL;
			base   = 9'd0;
		end
		floor_prod    = (FULL_SCALE - saturation) * value_level;
		nxt.sector    = sector;
		nxt.frac      = 6'(hue_c - base);
		nxt.top       = value_level;
		nxt.floor_lvl = floor_prod[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = data_s1;

endmodule

// ===== rtl/hsvrgb_ramp.sv =====
// Second and third pipeline stages: ramp products, division by sixty and the
// per-sector choice of top, floor and ramp levels. Depends on hsvrgb_pkg.
module hsvrgb_ramp import hsvrgb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  sect_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output rgb_t  out_data
);

	logic        v_s2;
	logic        v_s3;
	logic        rdy_s3;
	sector_t     sector_s2;
	logic [7:0]  top_s2;
	logic [7:0]  floor_s2;
	logic [13:0] rise_prod_s2;
	logic [13:0] fall_prod_s2;
	rgb_t        lvl_s3;

	logic [7:0]  span;
	logic [5:0]  frac_inv;
	logic [24:0] rise_q;
	logic [24:0] fall_q;
	logic [7:0]  rising;
	logic [7:0]  falling;
	rgb_t        lvl;

	assign rdy_s3   = !v_s3 || out_ready;
	assign in_ready = !v_s2 || rdy_s3;

	always_comb begin
		span     = in_data.top - in_data.floor_lvl;
		frac_inv = 6'(SECTOR_DEG) - in_data.frac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s2 <= in_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sector_s2    <= in_data.sector;
			top_s2       <= in_data.top;
			floor_s2     <= in_data.floor_lvl;
			rise_prod_s2 <= span * in_data.frac;
			fall_prod_s2 <= span * frac_inv;
		end
	end

	// Dividing by sixty: drop two bits, then multiply by the reciprocal of fifteen.
	always_comb begin
		rise_q  = rise_prod_s2[13:2] * RECIP15;
		fall_q  = fall_prod_s2[13:2] * RECIP15;
		rising  = rise_q[23:16] + floor_s2;
		falling = fall_q[23:16] + floor_s2;
		unique case (sector_s2)
			SEC_RED_YEL: lvl = '{red: top_s2,   green: rising,   blue: floor_s2};
			SEC_YEL_GRN: lvl = '{red: falling,  green: top_s2,   blue: floor_s2};
			SEC_GRN_CYN: lvl = '{red: floor_s2, green: top_s2,   blue: rising};
			SEC_CYN_BLU: lvl = '{red: floor_s2, green: falling,  blue: top_s2};
			SEC_BLU_MAG: lvl = '{red: rising,   green: floor_s2, blue: top_s2};
			default:     lvl = '{red: top_s2,   green: floor_s2, blue: falling};
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			lvl_s3 <= lvl;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = lvl_s3;

endmodule

// ===== rtl/hsvrgb_scale.sv =====
// Fourth and fifth pipeline stages: brightness multiply and division by 255.
// The fifth stage is the output register. Depends on hsvrgb_pkg.
module hsvrgb_scale import hsvrgb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  rgb_t       in_data,
	input  logic [7:0] max_brightness,
	output logic       out_valid,
	input  logic       out_ready,
	output rgb_t       out_data
);

	logic        v_s4;
	logic        v_s5;
	logic        rdy_s5;
	logic [15:0] r_prod_s4;
	logic [15:0] g_prod_s4;
	logic [15:0] b_prod_s4;
	rgb_t        res_s5;

	logic [15:0] r_sum;
	logic [15:0] g_sum;
	logic [15:0] b_sum;

	assign rdy_s5   = !v_s5 || out_ready;
	assign in_ready = !v_s4 || rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s4 <= in_valid;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			r_prod_s4 <= in_data.red * max_brightness;
			g_prod_s4 <= in_data.green * max_brightness;
			b_prod_s4 <= in_data.blue * max_brightness;
		end
	end

	// floor(y / 255) == (y + (y >> 8) + 1) >> 8 for every 16-bit y up to 255 * 255.
	always_comb begin
		r_sum = r_prod_s4 + 16'(r_prod_s4[15:8]) + 16'd1;
		g_sum = g_prod_s4 + 16'(g_prod_s4[15:8]) + 16'd1;
		b_sum = b_prod_s4 + 16'(b_prod_s4[15:8]) + 16'd1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			res_s5.red   <= r_sum[15:8];
			res_s5.green <= g_sum[15:8];
			res_s5.blue  <= b_sum[15:8];
		end
	end

	assign out_valid = v_s5;
	assign out_data  = res_s5;

endmodule

// ===== rtl/hsv_to_rgb_scaled_unit.sv =====
// Top level of the HSV to RGB converter: configuration registers and the pipeline.
// Depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_ramp and hsvrgb_scale.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[8:0] hue
//  m_axis    out        tdata[7:0] red, [15:8] green, [23:16] blue
//  cfg       in         cfg_index selects saturation, value_level, max_brightness
//
// Five register stages; a result is offered on m_axis once its input beat has
// passed through all five. One beat per cycle is taken and delivered while the
// output side is ready. A stall on m_axis holds each full stage whose next stage
// is full too; empty stages still fill, so up to five beats are in flight.
// Reset clears the stage valid bits and loads the register defaults (255, 80, 250).
module hsv_to_rgb_scaled_unit import hsvrgb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [8:0] hue, rest zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] saturation_q;
	logic [7:0] value_level_q;
	logic [7:0] max_brightness_q;

	logic  sect_valid;
	logic  sect_ready;
	sect_t sect_data;
	logic  lvl_valid;
	logic  lvl_ready;
	rgb_t  lvl_data;
	rgb_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saturation_q     <= SAT_RESET;
			value_level_q    <= VAL_RESET;
			max_brightness_q <= BRI_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SATURATION:     saturation_q     <= cfg_data;
				CFG_VALUE_LEVEL:    value_level_q    <= cfg_data;
				CFG_MAX_BRIGHTNESS: max_brightness_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	hsvrgb_sector u_sector (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.hue         (s_axis_tdata[8:0]),
		.saturation  (saturation_q),
		.value_level (value_level_q),
		.out_valid   (sect_valid),
		.out_ready   (sect_ready),
		.out_data    (sect_data)
	);

	hsvrgb_ramp u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sect_valid),
		.in_ready  (sect_ready),
		.in_data   (sect_data),
		.out_valid (lvl_valid),
		.out_ready (lvl_ready),
		.out_data  (lvl_data)
	);

	hsvrgb_scale u_scale (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (lvl_valid),
		.in_ready       (lvl_ready),
		.in_data        (lvl_data),
		.max_brightness (max_brightness_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_data       (res)
	);

	assign m_axis_tdata = {res.blue, res.green, res.red};

endmodule
